@@ rtl/frame_time_smoother_macros.svh @@
// Assertion macros shared by the frame time smoother RTL.
`ifndef FRAME_TIME_SMOOTHER_MACROS_SVH
`define FRAME_TIME_SMOOTHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame time smoother assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame time smoother assertion failed");

`endif

@@ rtl/fts_pkg.sv @@
// Package with constants, types and register codes of the frame time smoother.
`default_nettype none
package fts_pkg;

  localparam int HISTORY_DEPTH = 32;
  localparam int AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int WIN_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int PUSH_CLAMP = 400000;
  localparam int SUM_W  = $clog2(HISTORY_DEPTH * PUSH_CLAMP + 1);
  localparam int DIV_W  = (SUM_W + 1 > 25) ? SUM_W + 1 : 25;

  localparam logic [23:0] RESET_FRAME_US = 24'd33333;
  localparam logic [23:0] PUSH_CLAMP_US  = 24'd400000;
  localparam logic [23:0] PAUSE_LIMIT_US = 24'd100;
  localparam logic [23:0] WINDOW_NUM_US  = 24'd500000;
  localparam logic [23:0] SAT_24         = 24'hFFFFFF;

  localparam logic [2:0] REG_TIMER_EN  = 3'd0;
  localparam logic [2:0] REG_SMOOTH_EN = 3'd1;
  localparam logic [2:0] REG_FIXED     = 3'd2;
  localparam logic [2:0] REG_MAX_STEP  = 3'd3;
  localparam logic [2:0] REG_SCALE     = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SAT,
    ST_PUSH,
    ST_WWAIT,
    ST_SUM,
    ST_AVG,
    ST_AVGW,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [DIV_W-1:0]  quotient;
  } div_rsp_t;

  typedef struct packed {
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [23:0]    wr_data;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
  } hist_req_t;

endpackage
`default_nettype wire

@@ rtl/fts_div.sv @@
// Restoring unsigned divider producing one quotient bit per cycle.
`default_nettype none
`include "frame_time_smoother_macros.svh"
module fts_div
  import fts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  localparam int CW = (DIV_W > 1) ? $clog2(DIV_W) : 1;

  logic             busy_r;
  logic [CW-1:0]    cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] dsr_r;
  logic [DIV_W:0]   shift;
  logic [DIV_W:0]   diff;
  logic             q_bit;

  assign shift = {rem_r, quo_r[DIV_W-1]};
  assign diff  = shift - {1'b0, dsr_r};
  assign q_bit = (shift >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DIV_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= q_bit ? diff[DIV_W-1:0] : shift[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], q_bit};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.quotient = quo_r;

  `FTS_ASSERT_IMP(a_no_restart, clk, rst_n, req.start, !busy_r)
  `FTS_ASSERT_NXT(a_start_busy, clk, rst_n, req.start, busy_r && cnt_r == CW'(DIV_W - 1))

endmodule
`default_nettype wire

@@ rtl/fts_hist.sv @@
// Frame time history memory with per-entry valid bits and registered read data.
`default_nettype none
module fts_hist
  import fts_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  hist_req_t  req,
  output logic [23:0] rd_data
);

  logic [23:0]              mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] valid_r;
  logic [23:0]              rdata_r;
  logic                     rvalid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rvalid_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rvalid_r ? rdata_r : RESET_FRAME_US;

endmodule
`default_nettype wire

@@ rtl/frame_time_smoother.sv @@
// Top level of the frame time smoother: registers, sequencer and output stage.
// With smoothing off, an input passes through ST_MUL, ST_SAT and ST_OUT to the output register.
// With smoothing on, the sequencer also runs up to two bit-serial divisions and one
// history read per averaged entry.
// A new input is taken only in ST_IDLE, in the cycle after the result is registered.
// Synchronous active-low reset restores the registers and marks the history as 33333 us.
`default_nettype none
`include "frame_time_smoother_macros.svh"
module frame_time_smoother
  import fts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [23:0] real_frame_us
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [23:0] game_frame_us, [29:24] window_used
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  state_t state_r, state_nxt;

  logic        timer_en_r;
  logic        smooth_en_r;
  logic [19:0] fixed_r;
  logic [23:0] max_step_r;
  logic [15:0] scale_r;

  logic [23:0] step_r;
  logic [39:0] prod_r;
  logic [23:0] res_r;
  logic [23:0] pushed_r;
  logic [23:0] last_avg_r;
  logic [AW-1:0]    head_r;
  logic [AW-1:0]    rd_addr_r;
  logic [WIN_W-1:0] win_r;
  logic [WIN_W-1:0] iss_cnt_r;
  logic             rd_pend_r;
  logic [SUM_W-1:0] sum_r;
  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  hist_req_t hist_req;
  logic [23:0] hist_rd_data;

  logic [AW-1:0]    head_inc;
  logic [AW-1:0]    rd_addr_dec;
  logic [23:0]      scaled;
  logic [WIN_W-1:0] win_calc;
  logic [23:0]      avg_res;
  logic             accept;

  fts_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  fts_hist u_hist (
    .clk (clk),
    .rst_n (rst_n),
    .req (hist_req),
    .rd_data (hist_rd_data)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign head_inc    = (head_r == AW'(HISTORY_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign rd_addr_dec = (rd_addr_r == '0) ? AW'(HISTORY_DEPTH - 1) : rd_addr_r - 1'b1;
  assign scaled      = (prod_r[39:32] != 8'd0) ? SAT_24 : prod_r[31:8];

  always_comb begin
    if (last_avg_r == 24'd0 || div_rsp.quotient == '0) begin
      win_calc = WIN_W'(1);
    end else if (div_rsp.quotient >= DIV_W'(HISTORY_DEPTH)) begin
      win_calc = WIN_W'(HISTORY_DEPTH);
    end else begin
      win_calc = WIN_W'(div_rsp.quotient);
    end
  end

  assign avg_res = (pushed_r < PAUSE_LIMIT_US) ? pushed_r : div_rsp.quotient[23:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_en_r  <= 1'b1;
      smooth_en_r <= 1'b1;
      fixed_r     <= 20'd0;
      max_step_r  <= 24'd250000;
      scale_r     <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TIMER_EN:  timer_en_r  <= cfg_data[0];
        REG_SMOOTH_EN: smooth_en_r <= cfg_data[0];
        REG_FIXED:     fixed_r     <= cfg_data[19:0];
        REG_MAX_STEP:  max_step_r  <= cfg_data;
        REG_SCALE:     scale_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_req   = '0;
    hist_req  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && timer_en_r) begin
          state_nxt = ST_MUL;
          if (smooth_en_r && last_avg_r != 24'd0) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(WINDOW_NUM_US) + DIV_W'(last_avg_r);
            div_req.divisor  = DIV_W'({last_avg_r, 1'b0});
          end
        end
      end
      ST_MUL: state_nxt = ST_SAT;
      ST_SAT: state_nxt = smooth_en_r ? ST_PUSH : ST_OUT;
      ST_PUSH: begin
        hist_req.wr_en   = 1'b1;
        hist_req.wr_addr = head_inc;
        hist_req.wr_data = pushed_r;
        state_nxt        = ST_WWAIT;
      end
      ST_WWAIT: begin
        if (!div_rsp.busy) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (iss_cnt_r != win_r) begin
          hist_req.rd_en   = 1'b1;
          hist_req.rd_addr = rd_addr_r;
        end else if (!rd_pend_r) begin
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(sum_r) + DIV_W'(win_r >> 1);
        div_req.divisor  = DIV_W'(win_r);
        state_nxt        = ST_AVGW;
      end
      ST_AVGW: begin
        if (!div_rsp.busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_avg_r <= RESET_FRAME_US;
      head_r     <= '0;
      rd_pend_r  <= 1'b0;
    end else begin
      rd_pend_r <= hist_req.rd_en;
      if (state_r == ST_PUSH) begin
        head_r <= head_inc;
      end
      if (state_r == ST_AVGW && !div_rsp.busy) begin
        last_avg_r <= avg_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step_r <= (fixed_r != 20'd0) ? 24'(fixed_r)
              : ((in_tdata < max_step_r) ? in_tdata : max_step_r);
    end
    if (state_r == ST_MUL) begin
      prod_r <= step_r * scale_r + 40'd128;
    end
    if (state_r == ST_SAT) begin
      res_r    <= scaled;
      pushed_r <= (scaled > PUSH_CLAMP_US) ? PUSH_CLAMP_US : scaled;
      win_r    <= WIN_W'(1);
    end
    if (state_r == ST_WWAIT && !div_rsp.busy) begin
      win_r     <= win_calc;
      iss_cnt_r <= '0;
      rd_addr_r <= head_r;
      sum_r     <= '0;
    end
    if (state_r == ST_SUM) begin
      if (hist_req.rd_en) begin
        iss_cnt_r <= iss_cnt_r + 1'b1;
        rd_addr_r <= rd_addr_dec;
      end
      if (rd_pend_r) begin
        sum_r <= sum_r + SUM_W'(hist_rd_data);
      end
    end
    if (state_r == ST_AVGW && !div_rsp.busy) begin
      res_r <= avg_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_OUT && (!out_tvalid_r || out_tready)) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= {2'b00, 6'(win_r), res_r};
    end
  end

  `FTS_ASSERT_IMP(a_win_range, clk, rst_n, state_r == ST_SUM,
                  win_r != '0 && win_r <= WIN_W'(HISTORY_DEPTH))
  `FTS_ASSERT_IMP(a_out_from_seq, clk, rst_n, $rose(out_tvalid_r), $past(state_r == ST_OUT))
  `FTS_ASSERT_IMP(a_read_div_idle, clk, rst_n, hist_req.rd_en, !div_rsp.busy)

endmodule
`default_nettype wire
